[rtl/core/ccfr_pkg.sv]
// Shared types, constants and codes of the COBS/CRC frame receiver.
package ccfr_pkg;

    localparam logic [15:0] CRC_INIT  = 16'hFFFF;
    localparam logic [15:0] CRC_POLY  = 16'h1021;
    localparam logic [7:0]  FULL_CODE = 8'hFF;
    localparam logic [16:0] COUNT_MAX = 17'h1FFFF;
    localparam logic [15:0] LEN_MAX   = 16'hFFFF;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_SHORT   = 2'd1,
        ST_CRC_BAD = 2'd2
    } status_t;

    typedef struct packed {
        logic [15:0] payload_length;
        status_t     frame_status;
        logic        frame_end;
        logic [7:0]  payload_byte;
    } result_t;

endpackage

[rtl/core/ccfr_crc16.sv]
// Byte-wide CRC-16/CCITT-FALSE update, MSB first, no reflection.
module ccfr_crc16 (
    input  logic [15:0] crc_in,
    input  logic [7:0]  data_in,
    output logic [15:0] crc_out
);
    import ccfr_pkg::*;

    always_comb
    begin
        logic [15:0] c;
        c = crc_in ^ {data_in, 8'h00};
        for (int k = 0; k < 8; k++)
        begin
            if (c[15])
            begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[14:0], 1'b0};
            end
        end
        crc_out = c;
    end

endmodule

[rtl/core/ccfr_decoder.sv]
// Frame state: COBS decode, CRC capture and check, one result per request at most.
module ccfr_decoder (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_take,
    input  logic [7:0]           in_byte,
    input  logic                 crc_low_byte_first,
    output logic                 res_valid,
    output ccfr_pkg::result_t    res
);
    import ccfr_pkg::*;

    logic [15:0] running_crc_reg, running_crc_next;
    logic [15:0] received_crc_reg, received_crc_next;
    logic [16:0] decoded_count_reg, decoded_count_next;
    logic [7:0]  block_remaining_reg, block_remaining_next;
    logic        block_is_full_reg, block_is_full_next;
    logic        zero_pending_reg, zero_pending_next;
    logic        frame_open_reg, frame_open_next;

    logic [7:0]  dec_byte;
    logic [15:0] crc_upd;
    logic [15:0] expect_crc;
    logic [16:0] len_full;

    // Decoded byte: the held implied zero at a code byte, else the literal.
    assign dec_byte   = (block_remaining_reg == 8'd0) ? 8'h00 : in_byte;
    assign expect_crc = crc_low_byte_first ?
                        {received_crc_reg[7:0], received_crc_reg[15:8]} : received_crc_reg;
    assign len_full   = decoded_count_reg - 17'd2;

    ccfr_crc16 u_crc (
        .crc_in  (running_crc_reg),
        .data_in (dec_byte),
        .crc_out (crc_upd)
    );

    always_comb
    begin
        logic take;
        running_crc_next     = running_crc_reg;
        received_crc_next    = received_crc_reg;
        decoded_count_next   = decoded_count_reg;
        block_remaining_next = block_remaining_reg;
        block_is_full_next   = block_is_full_reg;
        zero_pending_next    = zero_pending_reg;
        frame_open_next      = frame_open_reg;
        res_valid            = 1'b0;
        res                  = '0;
        take                 = 1'b0;

        if (in_take)
        begin
            if (in_byte == 8'h00)
            begin
                if (frame_open_reg)
                begin
                    res_valid     = 1'b1;
                    res.frame_end = 1'b1;
                    if (decoded_count_reg < 17'd2)
                    begin
                        res.frame_status = ST_SHORT;
                    end
                    else
                    begin
                        res.frame_status   = (expect_crc == running_crc_reg) ? ST_OK
                                                                            : ST_CRC_BAD;
                        res.payload_length = len_full[16] ? LEN_MAX : len_full[15:0];
                    end
                    running_crc_next     = CRC_INIT;
                    received_crc_next    = '0;
                    decoded_count_next   = '0;
                    block_remaining_next = '0;
                    block_is_full_next   = 1'b0;
                    zero_pending_next    = 1'b0;
                    frame_open_next      = 1'b0;
                end
            end
            else
            begin
                frame_open_next = 1'b1;
                if (block_remaining_reg == 8'd0)
                begin
                    // Code byte: flush a held zero, open the next block.
                    take                 = zero_pending_reg;
                    block_remaining_next = in_byte - 8'd1;
                    block_is_full_next   = (in_byte == FULL_CODE);
                    zero_pending_next    = (in_byte == 8'd1);
                end
                else
                begin
                    take                 = 1'b1;
                    block_remaining_next = block_remaining_reg - 8'd1;
                    zero_pending_next    = (block_remaining_reg == 8'd1) && !block_is_full_reg;
                end
            end
        end

        if (take)
        begin
            if (decoded_count_reg < 17'd2)
            begin
                received_crc_next  = {received_crc_reg[7:0], dec_byte};
                decoded_count_next = decoded_count_reg + 17'd1;
            end
            else
            begin
                running_crc_next = crc_upd;
                if (decoded_count_reg != COUNT_MAX)
                begin
                    decoded_count_next = decoded_count_reg + 17'd1;
                end
                res_valid        = 1'b1;
                res.payload_byte = dec_byte;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_crc_reg     <= CRC_INIT;
            received_crc_reg    <= '0;
            decoded_count_reg   <= '0;
            block_remaining_reg <= '0;
            block_is_full_reg   <= 1'b0;
            zero_pending_reg    <= 1'b0;
            frame_open_reg      <= 1'b0;
        end
        else
        begin
            running_crc_reg     <= running_crc_next;
            received_crc_reg    <= received_crc_next;
            decoded_count_reg   <= decoded_count_next;
            block_remaining_reg <= block_remaining_next;
            block_is_full_reg   <= block_is_full_next;
            zero_pending_reg    <= zero_pending_next;
            frame_open_reg      <= frame_open_next;
        end
    end

endmodule

[rtl/core/ccfr_out_skid.sv]
// Result register with one skid entry between the decoder and the output stream.
module ccfr_out_skid (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  ccfr_pkg::result_t    push_data,
    output logic                 can_push,
    output logic                 out_valid,
    input  logic                 out_ready,
    output ccfr_pkg::result_t    out_data
);
    import ccfr_pkg::*;

    logic    main_valid_reg, main_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t main_reg, main_next;
    result_t skid_reg, skid_next;

    assign can_push  = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

    always_comb
    begin
        logic drain;
        drain           = main_valid_reg && out_ready;
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;

        if (drain)
        begin
            main_valid_next = skid_valid_reg;
            main_next       = skid_reg;
            skid_valid_next = 1'b0;
        end
        if (push)
        begin
            if (!main_valid_reg || drain)
            begin
                main_valid_next = 1'b1;
                main_next       = push_data;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_next       = push_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

endmodule

[rtl/core/cobs_crc_frame_receiver_core.sv]
// Top level of the COBS deframer with CRC-16/CCITT-FALSE check.
//
// Input stream s_*: one raw received byte per request in s_tdata; a zero byte
// delimits frames, and a delimiter right after another delimiter is dropped.
// Output stream m_*: one request per decoded payload byte (m_tlast low), and
// one end request per frame (m_tlast high) whose m_tuser carries the status
// (ok, too short, CRC mismatch) and whose m_tdata upper bits carry the
// payload length, saturating at 65535. Payload bytes leave before the check,
// so the consumer drops the frame's bytes on a bad status.
// The first two decoded bytes of a frame are the CRC; cfg_wen/cfg_wdata set
// the byte order (1: low byte first). It is read when the end request forms.
// Results are registered in the result register, or the skid entry while it is
// held. Throughput: one byte per cycle while s_tready is high; the byte-wide CRC
// update and COBS block counter are combinational from frame state to register.
// Stall: a result register plus one skid entry let one more byte be accepted
// while m_tready is low; s_tready then drops until the consumer drains.
// Reset: frame state clears, the byte order register returns to low first,
// and both output entries empty.
module cobs_crc_frame_receiver_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wen,
    input  logic        cfg_wdata,     // crc_low_byte_first
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,       // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,       // [7:0] payload_byte, [23:8] payload_length
    output logic        m_tlast,       // frame_end
    output logic [1:0]  m_tuser        // [1:0] frame_status
);
    import ccfr_pkg::*;

    logic    crc_low_byte_first_reg;
    logic    in_take;
    logic    res_valid;
    result_t res;
    result_t out_res;

    // Byte order register: write whenever enabled.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_low_byte_first_reg <= 1'b1;
        end
        else if (cfg_wen)
        begin
            crc_low_byte_first_reg <= cfg_wdata;
        end
    end

    // Accept a byte whenever the skid entry is free.
    assign in_take = s_tvalid && s_tready;

    ccfr_decoder u_decoder (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_take            (in_take),
        .in_byte            (s_tdata),
        .crc_low_byte_first (crc_low_byte_first_reg),
        .res_valid          (res_valid),
        .res                (res)
    );

    ccfr_out_skid u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .can_push  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_res)
    );

    // Pack the result fields onto the stream.
    assign m_tdata = {out_res.payload_length, out_res.payload_byte};
    assign m_tlast = out_res.frame_end;
    assign m_tuser = out_res.frame_status;

endmodule

[rtl/core/ccfr_checker.sv]
// Port-level checks of the frame receiver, bound to the top level.
module ccfr_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,
    input  logic        m_tlast,
    input  logic [1:0]  m_tuser
);
    import ccfr_pkg::*;

    // Hold a stalled result.
    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("m_tvalid dropped while stalled");

    a_data_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable({m_tdata, m_tlast, m_tuser}))
        else $error("result changed while stalled");

    a_end_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tdata[7:0] == 8'h00)
        else $error("end request carries a payload byte");

    a_payload_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> m_tuser == ST_OK && m_tdata[23:8] == 16'h0000)
        else $error("payload request carries status or length");

    a_short_len_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast && m_tuser == ST_SHORT |-> m_tdata[23:8] == 16'h0000)
        else $error("short frame reports a length");

endmodule

bind cobs_crc_frame_receiver_core ccfr_checker u_ccfr_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);
